/* rtl/core/slrc_pkg.sv */
// ----------------------------------------------------------------------------
// slrc_pkg
// Shared constants, types and log2/exp2 table builders for the look curve.
// ----------------------------------------------------------------------------
package slrc_pkg;

  localparam int LOG_BITS  = 8;
  localparam int EXP_BITS  = 8;
  localparam int LOG_SIZE  = 1 << LOG_BITS;
  localparam int EXP_SIZE  = 1 << EXP_BITS;
  localparam int LOG_SH    = 16 - LOG_BITS;
  localparam int EXP_SH    = 16 - EXP_BITS;
  localparam int LOG_W     = 17;   // entries up to 65536
  localparam int EXP_W     = 18;   // entries up to 131072
  localparam int DIV_STEPS = 17;
  // input stage, divider load stage, divider steps, then nine stages of log,
  // power, exp, shift, scale
  localparam int LANE_LAT  = 2 + DIV_STEPS + 9;

  localparam int REG_AW = 5;
  localparam logic [2:0] REG_DEADZONE = 3'd0;
  localparam logic [2:0] REG_EXPONENT = 3'd1;
  localparam logic [2:0] REG_SCALE    = 3'd2;
  localparam logic [2:0] REG_SENS     = 3'd3;
  localparam logic [2:0] REG_INVERT   = 3'd4;

  localparam logic [14:0] DEADZONE_MIN = 15'd1638;
  localparam logic [11:0] EXPONENT_MIN = 12'd256;
  localparam logic [15:0] SCALE_MIN    = 16'd256;
  localparam logic [15:0] SENS_MIN     = 16'd256;
  localparam logic [11:0] EXPONENT_RST = 12'd512;
  localparam logic [15:0] SCALE_RST    = 16'd3072;

  typedef struct packed {
    logic [14:0] deadzone;
    logic [11:0] exponent;
    logic [15:0] scale;
    logic [15:0] sens;
    logic        invert;
  } cfg_t;

  // travels with an axis beat through the divider
  typedef struct packed {
    logic zero;
    logic neg;
  } side_t;

  typedef logic [LOG_W-1:0] log_tab_t [0:LOG_SIZE];
  typedef logic [EXP_W-1:0] exp_tab_t [0:EXP_SIZE];

  function automatic logic [63:0] int_sqrt(input logic [63:0] xin);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = xin;
    r = 64'd0;
    b = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (b > x) b = b >> 2;
    end
    for (int j = 0; j < 32; j++) begin
      if (b != 64'd0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // log2(1 + i/size) in Q0.16 by repeated squaring
  function automatic log_tab_t build_log();
    log_tab_t    tab;
    logic [63:0] x;
    logic [63:0] r;
    for (int i = 0; i < LOG_SIZE; i++) begin
      x = (64'd1 << 30) + (64'(i) << (30 - LOG_BITS));
      r = 64'd0;
      for (int k = 0; k < 18; k++) begin
        x = (x * x) >> 30;
        r = r << 1;
        if (x >= (64'd1 << 31)) begin
          x = x >> 1;
          r = r | 64'd1;
        end
      end
      tab[i] = LOG_W'((r + 64'd2) >> 2);
    end
    tab[LOG_SIZE] = LOG_W'(65536);
    return tab;
  endfunction

  // 2^(i/size) in Q1.16 as a product of roots of two
  function automatic exp_tab_t build_exp();
    exp_tab_t    tab;
    logic [63:0] roots [0:EXP_BITS];
    logic [63:0] acc;
    roots[0] = 64'd1 << 31;
    roots[1] = int_sqrt(64'd2 << 60);
    for (int k = 2; k <= EXP_BITS; k++) roots[k] = int_sqrt(roots[k-1] << 30);
    for (int i = 0; i < EXP_SIZE; i++) begin
      acc = 64'd1 << 30;
      for (int k = 0; k < EXP_BITS; k++) begin
        if (((i >> k) & 1) != 0)
          acc = (acc * roots[EXP_BITS-k] + (64'd1 << 29)) >> 30;
      end
      tab[i] = EXP_W'((acc + (64'd1 << 13)) >> 14);
    end
    tab[EXP_SIZE] = EXP_W'(131072);
    return tab;
  endfunction

  localparam log_tab_t LOG_TAB = build_log();
  localparam exp_tab_t EXP_TAB = build_exp();

endpackage

/* rtl/core/slrc_regs.sv */
// ----------------------------------------------------------------------------
// slrc_regs
// APB register file, writes raised to the enforced minimums.
// ----------------------------------------------------------------------------
module slrc_regs import slrc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [REG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t        cfg_r;
  cfg_t        cfg_nxt;
  logic        wr;
  logic [2:0]  idx;

  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (idx)
        REG_DEADZONE: cfg_nxt.deadzone = (pwdata[14:0] < DEADZONE_MIN) ?
                                         DEADZONE_MIN : pwdata[14:0];
        REG_EXPONENT: cfg_nxt.exponent = (pwdata[11:0] < EXPONENT_MIN) ?
                                         EXPONENT_MIN : pwdata[11:0];
        REG_SCALE:    cfg_nxt.scale = (pwdata[15:0] < SCALE_MIN) ?
                                      SCALE_MIN : pwdata[15:0];
        REG_SENS:     cfg_nxt.sens = (pwdata[15:0] < SENS_MIN) ?
                                     SENS_MIN : pwdata[15:0];
        REG_INVERT:   cfg_nxt.invert = pwdata[0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadzone <= DEADZONE_MIN;
      cfg_r.exponent <= EXPONENT_RST;
      cfg_r.scale    <= SCALE_RST;
      cfg_r.sens     <= SENS_MIN;
      cfg_r.invert   <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      REG_DEADZONE: prdata = {17'd0, cfg_r.deadzone};
      REG_EXPONENT: prdata = {20'd0, cfg_r.exponent};
      REG_SCALE:    prdata = {16'd0, cfg_r.scale};
      REG_SENS:     prdata = {16'd0, cfg_r.sens};
      REG_INVERT:   prdata = {31'd0, cfg_r.invert};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

/* rtl/core/slrc_div.sv */
// ----------------------------------------------------------------------------
// slrc_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module slrc_div import slrc_pkg::*; (
  input  logic                 clk,
  input  logic                 adv,
  input  logic [14:0]          num,
  input  logic [14:0]          den,
  input  side_t                side_in,
  output logic [DIV_STEPS-1:0] quo,
  output side_t                side_out
);

  // numerator never exceeds the divisor, so the remainder stays in 16 bits
  logic [16:0]          rem_r  [0:DIV_STEPS];
  logic [DIV_STEPS-1:0] quo_r  [0:DIV_STEPS];
  side_t                side_r [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0]  <= {2'd0, num};
      quo_r[0]  <= '0;
      side_r[0] <= side_in;
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    logic        ge;
    logic [16:0] sub;
    assign ge  = rem_r[j] >= {2'd0, den};
    assign sub = ge ? rem_r[j] - {2'd0, den} : rem_r[j];
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[j+1]  <= {sub[15:0], 1'b0};
        quo_r[j+1]  <= {quo_r[j][DIV_STEPS-2:0], ge};
        side_r[j+1] <= side_r[j];
      end
    end
  end

  assign quo      = quo_r[DIV_STEPS];
  assign side_out = side_r[DIV_STEPS];

endmodule

/* rtl/core/slrc_lane.sv */
// ----------------------------------------------------------------------------
// slrc_lane
// One axis: deadzone, rescale, power via log2/exp2, then scale and sensitivity.
// ----------------------------------------------------------------------------
module slrc_lane import slrc_pkg::*; (
  input  logic        clk,
  input  logic        adv,
  input  cfg_t        cfg,
  input  logic [15:0] stick,
  input  logic        neg_in,
  output logic [16:0] mag,
  output logic        neg_out
);

  // input stage
  logic [16:0] a;
  logic        zero_r;
  logic        neg_r;
  logic [14:0] num_r;
  logic [14:0] den;

  assign a   = stick[15] ? 17'h10000 - {1'b0, stick} : {1'b0, stick};
  assign den = 15'(16'd32768 - {1'b0, cfg.deadzone});

  always_ff @(posedge clk) begin
    if (adv) begin
      zero_r <= a <= {2'd0, cfg.deadzone};
      neg_r  <= neg_in;
      num_r  <= (a <= {2'd0, cfg.deadzone}) ? 15'd0 : 15'(a - {2'd0, cfg.deadzone});
    end
  end

  logic [DIV_STEPS-1:0] q;
  side_t                sd;

  slrc_div u_div (
    .clk      (clk),
    .adv      (adv),
    .num      (num_r),
    .den      (den),
    .side_in  ('{zero: zero_r, neg: neg_r}),
    .quo      (q),
    .side_out (sd)
  );

  // stage a: normalize
  logic [3:0]  p;
  logic [4:0]  k;
  logic [15:0] f16;
  side_t       sd_a_r;
  logic        full_a_r;
  logic [4:0]  k_a_r;
  logic [15:0] f_a_r;

  always_comb begin
    p = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (q[i]) p = 4'(i);
    end
  end
  assign k   = 5'd16 - {1'b0, p};
  assign f16 = 16'({q[15:0]} << k);

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_a_r   <= sd;
      full_a_r <= q[16];
      k_a_r    <= k;
      f_a_r    <= f16;
    end
  end

  // stage b: log table
  logic [LOG_BITS-1:0] lidx;
  logic [LOG_W-1:0]    llo;
  logic [LOG_W-1:0]    lhi;
  side_t               sd_b_r;
  logic                full_b_r;
  logic [4:0]          k_b_r;
  logic [LOG_W-1:0]    llo_b_r;
  logic [LOG_W-1:0]    ldif_b_r;
  logic [LOG_SH-1:0]   lrem_b_r;

  assign lidx = f_a_r[15:LOG_SH];
  assign llo  = LOG_TAB[lidx];
  assign lhi  = LOG_TAB[(LOG_BITS+1)'(lidx) + 1'b1];

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_b_r   <= sd_a_r;
      full_b_r <= full_a_r;
      k_b_r    <= k_a_r;
      llo_b_r  <= llo;
      ldif_b_r <= (lhi > llo) ? lhi - llo : '0;
      lrem_b_r <= f_a_r[LOG_SH-1:0];
    end
  end

  // stage c: log interpolation
  logic [LOG_W+LOG_SH:0] lprod;
  logic [LOG_W-1:0]      lv;
  side_t                 sd_c_r;
  logic                  full_c_r;
  logic [20:0]           g_c_r;

  assign lprod = (LOG_W+LOG_SH+1)'(ldif_b_r * lrem_b_r)
               + ((LOG_W+LOG_SH+1)'(1) << (LOG_SH - 1));
  assign lv    = llo_b_r + LOG_W'(lprod >> LOG_SH);

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_c_r   <= sd_b_r;
      full_c_r <= full_b_r;
      g_c_r    <= {k_b_r, 16'd0} - 21'(lv);
    end
  end

  // stage d: exponent times log
  side_t       sd_d_r;
  logic        full_d_r;
  logic [32:0] et_d_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_d_r   <= sd_c_r;
      full_d_r <= full_c_r;
      et_d_r   <= 33'(cfg.exponent * g_c_r);
    end
  end

  // stage e: split into shift and fraction, exp table
  logic [24:0]         t;
  logic [15:0]         u;
  logic [15:0]         v;
  logic [EXP_BITS-1:0] eidx;
  logic [EXP_W-1:0]    elo;
  logic [EXP_W-1:0]    ehi;
  side_t               sd_e_r;
  logic                full_e_r;
  logic [9:0]          s_e_r;
  logic [EXP_W-1:0]    elo_e_r;
  logic [EXP_W-1:0]    edif_e_r;
  logic [EXP_SH-1:0]   erem_e_r;

  assign t    = 25'((34'(et_d_r) + 34'd128) >> 8);
  assign u    = t[15:0];
  assign v    = 16'd0 - u;
  assign eidx = v[15:EXP_SH];
  assign elo  = EXP_TAB[eidx];
  assign ehi  = EXP_TAB[(EXP_BITS+1)'(eidx) + 1'b1];

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_e_r   <= sd_d_r;
      full_e_r <= full_d_r;
      s_e_r    <= {1'b0, t[24:16]} + {9'd0, (u != 16'd0)};
      elo_e_r  <= elo;
      edif_e_r <= (ehi > elo) ? ehi - elo : '0;
      erem_e_r <= v[EXP_SH-1:0];
    end
  end

  // stage f: exp interpolation
  logic [EXP_W+EXP_SH:0] eprod;
  side_t                 sd_f_r;
  logic                  full_f_r;
  logic [9:0]            s_f_r;
  logic [EXP_W-1:0]      ev_f_r;

  assign eprod = (EXP_W+EXP_SH+1)'(edif_e_r * erem_e_r)
               + ((EXP_W+EXP_SH+1)'(1) << (EXP_SH - 1));

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_f_r   <= sd_e_r;
      full_f_r <= full_e_r;
      s_f_r    <= s_e_r;
      ev_f_r   <= elo_e_r + EXP_W'(eprod >> EXP_SH);
    end
  end

  // stage g: rounding right shift, deadzone and full deflection overrides
  logic [EXP_W:0] rnd;
  logic [16:0]    c;
  logic           neg_g_r;
  logic [16:0]    c_g_r;

  always_comb begin
    rnd = '0;
    if (sd_f_r.zero) begin
      c = 17'd0;
    end else if (full_f_r) begin
      c = 17'h10000;
    end else if (s_f_r == 10'd0) begin
      c = 17'(ev_f_r);
    end else if (s_f_r > 10'(EXP_W)) begin
      c = 17'd0;
    end else begin
      rnd = {1'b0, ev_f_r} + ((EXP_W+1)'(1) << (s_f_r[4:0] - 5'd1));
      c   = 17'(rnd >> s_f_r[4:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      neg_g_r <= sd_f_r.neg;
      c_g_r   <= c;
    end
  end

  // stage h and i: scale then sensitivity
  logic        neg_h_r;
  logic [32:0] m1_h_r;
  logic [48:0] m2;
  logic        neg_i_r;
  logic [16:0] mag_i_r;

  assign m2 = 49'(m1_h_r * cfg.sens);

  always_ff @(posedge clk) begin
    if (adv) begin
      neg_h_r <= neg_g_r;
      m1_h_r  <= 33'(c_g_r * cfg.scale);
      neg_i_r <= neg_h_r;
      mag_i_r <= m2[48:32];
    end
  end

  assign mag     = mag_i_r;
  assign neg_out = neg_i_r;

endmodule

/* rtl/core/stick_look_response_curve.sv */
// ----------------------------------------------------------------------------
// stick_look_response_curve
// Two-axis stick to look delta conversion with deadzone and power curve.
// ----------------------------------------------------------------------------
// Input channel in_*: one stick sample per beat (x, y in Q1.15 and an enable
// flag). Output channel out_*: one pair of integer look deltas per beat.
// A sample with look_enabled low, or whose deltas both come out zero, gives
// no output beat.
// Throughput is one sample per cycle while the receiver does not stall. From input
// beat to output beat a sample passes one input stage, a divider load stage and 17
// divider stages (one quotient bit each), nine stages of log, power, exp and
// scaling, then the output register.
// The whole pipeline moves as one; when the receiver stalls a waiting output
// beat, in_stall rises and every stage holds its contents.
// Registers sit on an APB port and may be written only while no sample is in
// flight. Reset clears the registers to their defaults and empties the
// pipeline; the log2/exp2 tables are constant logic.
// ----------------------------------------------------------------------------
module stick_look_response_curve import slrc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_stick_x,
  input  logic signed [15:0] in_stick_y,
  input  logic               in_look_enabled,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [16:0] out_delta_x,
  output logic signed [16:0] out_delta_y,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [REG_AW-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t cfg;

  slrc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic adv;
  logic out_valid_r;

  assign in_stall = out_valid_r & out_stall;
  assign adv      = ~in_stall;

  logic [16:0] mag_x;
  logic [16:0] mag_y;
  logic        neg_x;
  logic        neg_y;
  logic        negy_in;

  assign negy_in = cfg.invert ? in_stick_y[15] : ~in_stick_y[15];

  slrc_lane u_lane_x (
    .clk     (clk),
    .adv     (adv),
    .cfg     (cfg),
    .stick   (in_stick_x),
    .neg_in  (in_stick_x[15]),
    .mag     (mag_x),
    .neg_out (neg_x)
  );

  slrc_lane u_lane_y (
    .clk     (clk),
    .adv     (adv),
    .cfg     (cfg),
    .stick   (in_stick_y),
    .neg_in  (negy_in),
    .mag     (mag_y),
    .neg_out (neg_y)
  );

  // valid bits travel alongside the lanes
  logic [LANE_LAT-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LANE_LAT-2:0], in_valid & in_look_enabled};
    end
  end

  logic               keep;
  logic signed [16:0] dx_r;
  logic signed [16:0] dy_r;

  assign keep = vld_r[LANE_LAT-1] & ((mag_x != 17'd0) | (mag_y != 17'd0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= keep;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r <= neg_x ? $signed(17'd0 - mag_x) : $signed(mag_x);
      dy_r <= neg_y ? $signed(17'd0 - mag_y) : $signed(mag_y);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_delta_x = dx_r;
  assign out_delta_y = dy_r;

`ifndef ASSERT_OFF
  a_no_zero_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_delta_x != 17'sd0 || out_delta_y != 17'sd0))
    else $error("output beat with both deltas zero");

  a_delta_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_delta_x >= -17'sd65534 && out_delta_x <= 17'sd65534 &&
                   out_delta_y >= -17'sd65534 && out_delta_y <= 17'sd65534))
    else $error("delta out of range");

  a_disabled_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !in_look_enabled) |=> !vld_r[0])
    else $error("disabled sample entered pipeline");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && vld_r == '0))
    else $error("pipeline not empty after reset");
`endif

endmodule

/* bench/stick_look_response_curve_tb.sv */
// ----------------------------------------------------------------------------
// stick_look_response_curve_tb
// Drives stick samples through the look curve block under several register
// settings and idle/stall patterns, and checks every output beat against a
// built-in fixed-point predictor of the deadzone, power curve and scaling.
// ----------------------------------------------------------------------------
module stick_look_response_curve_tb;
  import slrc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic signed [16:0] dx;
    logic signed [16:0] dy;
  } delta_t;

  typedef struct {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic               en;
    logic               fixed;  // expected result typed into the row
    logic               has;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_stick_x = '0;
  logic signed [15:0] in_stick_y = '0;
  logic in_look_enabled = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [16:0] out_delta_x;
  logic signed [16:0] out_delta_y;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [REG_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  stick_look_response_curve dut (.*);

  always #2 clk = ~clk;

  // predictor copy of the registers and tables
  logic [14:0] dz_q;
  logic [11:0] exp_q;
  logic [15:0] scale_q;
  logic [15:0] sens_q;
  logic        inv_q;
  logic [31:0] log_lut [0:256];
  logic [31:0] exp_lut [0:256];

  delta_t pending_deltas [$];
  int errors = 0;
  int cycles = 0;
  int beats_in = 0;
  int beats_out = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] x, r, b;
    x = v; r = 0; b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic make_luts();
    logic [63:0] x, r, acc;
    logic [63:0] rt [0:8];
    for (int i = 0; i < 256; i++) begin
      x = (64'd1 << 30) + (64'(i) << 22);
      r = 0;
      for (int k = 0; k < 18; k++) begin
        x = (x * x) >> 30;
        r <<= 1;
        if (x >= (64'd1 << 31)) begin
          x >>= 1;
          r |= 1;
        end
      end
      log_lut[i] = 32'((r + 2) >> 2);
    end
    log_lut[256] = 65536;
    rt[0] = 64'd1 << 31;
    rt[1] = isqrt(64'd2 << 60);
    for (int k = 2; k <= 8; k++) rt[k] = isqrt(rt[k-1] << 30);
    for (int i = 0; i < 256; i++) begin
      acc = 64'd1 << 30;
      for (int k = 0; k < 8; k++)
        if ((i >> k) & 1) acc = (acc * rt[8-k] + (64'd1 << 29)) >> 30;
      exp_lut[i] = 32'((acc + (64'd1 << 13)) >> 14);
    end
    exp_lut[256] = 131072;
  endtask

  function automatic logic [31:0] lerp(input logic is_log, input logic [31:0] v);
    logic [31:0] idx, rem, lo, hi, diff;
    idx = (v & 32'hFFFF) >> 8;
    rem = v & 32'hFF;
    lo = is_log ? log_lut[idx] : exp_lut[idx];
    hi = is_log ? log_lut[idx+1] : exp_lut[idx+1];
    diff = (hi > lo) ? hi - lo : 0;
    return lo + 32'((64'(diff) * rem + 128) >> 8);
  endfunction

  function automatic logic [31:0] curved_mag(input logic [31:0] a);
    logic [31:0] d, n, f16, lv, g, t, u, v, ev, s;
    int p;
    d = dz_q;
    if (a <= d) return 0;
    n = 32'((64'(a - d) << 16) / 64'(32768 - d));
    if (n >= 65536) return 65536;
    p = 15;
    while (((n >> p) & 1) == 0) p--;
    f16 = (n << (16 - p)) & 32'hFFFF;
    lv = lerp(1'b1, f16);
    g = (16 - p) * 65536 - lv;
    t = 32'((64'(exp_q) * g + 128) >> 8);
    u = t & 32'hFFFF;
    s = (t >> 16) + (u != 0);
    v = (65536 - u) & 32'hFFFF;
    ev = lerp(1'b0, v);
    if (s == 0) return ev;
    if (s > 32) return 0;
    return 32'((64'(ev) + (64'd1 << (s - 1))) >> s);
  endfunction

  function automatic logic [31:0] look_mag(input logic [15:0] raw);
    logic [31:0] a, c;
    a = raw[15] ? 32'd65536 - raw : 32'(raw);
    c = curved_mag(a);
    return 32'((64'(c) * scale_q * sens_q) >> 32);
  endfunction

  // returns 1 when the sample yields an output beat
  function automatic logic predict_deltas(input logic [15:0] sx, input logic [15:0] sy,
                                          input logic en, output delta_t res);
    logic [31:0] mx, my;
    logic negy;
    res = '0;
    if (!en) return 0;
    mx = look_mag(sx);
    my = look_mag(sy);
    if (mx == 0 && my == 0) return 0;
    negy = inv_q ? sy[15] : !sy[15];
    res.dx = sy[15] === 1'bx ? '0 : (sx[15] ? -17'(mx) : 17'(mx));
    res.dy = negy ? -17'(my) : 17'(my);
    return 1;
  endfunction

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= REG_AW'({idx, 2'b00}); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_DEADZONE: dz_q = (val[14:0] < DEADZONE_MIN) ? DEADZONE_MIN : val[14:0];
      REG_EXPONENT: exp_q = (val[11:0] < EXPONENT_MIN) ? EXPONENT_MIN : val[11:0];
      REG_SCALE:    scale_q = (val[15:0] < SCALE_MIN) ? SCALE_MIN : val[15:0];
      REG_SENS:     sens_q = (val[15:0] < SENS_MIN) ? SENS_MIN : val[15:0];
      REG_INVERT:   inv_q = val[0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [31:0] dz, input logic [31:0] ex,
                          input logic [31:0] sc, input logic [31:0] se, input logic iv);
    reg_write(REG_DEADZONE, dz);
    reg_write(REG_EXPONENT, ex);
    reg_write(REG_SCALE, sc);
    reg_write(REG_SENS, se);
    reg_write(REG_INVERT, {31'd0, iv});
  endtask

  // one sample beat; expectation queued when the beat is accepted
  task automatic send_sample(input logic [15:0] sx, input logic [15:0] sy, input logic en);
    delta_t res;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_stick_x <= sx; in_stick_y <= sy; in_look_enabled <= en;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (predict_deltas(sx, sy, en, res)) pending_deltas.push_back(res);
    beats_in++;
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    while (pending_deltas.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_stick();
    int m;
    m = $urandom_range(9);
    if (m == 0) return 16'h8000;
    if (m == 1) return 16'h7FFF;
    if (m == 2) return 16'($urandom_range(2000));
    return 16'($urandom);
  endfunction

  // receiver side and checking
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
      if (out_valid && !out_stall) begin
        beats_out <= beats_out + 1;
        if (pending_deltas.size() == 0) begin
          $error("unexpected beat delta_x=%0d delta_y=%0d", out_delta_x, out_delta_y);
          errors++;
        end else begin
          automatic delta_t e = pending_deltas.pop_front();
          if (out_delta_x !== e.dx) begin
            $error("delta_x expected %0d actual %0d", e.dx, out_delta_x);
            errors++;
          end
          if (out_delta_y !== e.dy) begin
            $error("delta_y expected %0d actual %0d", e.dy, out_delta_y);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  row_t rows [$];

  task automatic add_row(input logic [15:0] sx, input logic [15:0] sy, input logic en,
                         input logic fx, input logic has,
                         input logic signed [16:0] dx, input logic signed [16:0] dy);
    row_t r;
    r.sx = sx; r.sy = sy; r.en = en; r.fixed = fx; r.has = has; r.dx = dx; r.dy = dy;
    rows.push_back(r);
  endtask

  initial begin
    delta_t res;
    logic has;
    make_luts();
    dz_q = DEADZONE_MIN; exp_q = EXPONENT_RST; scale_q = SCALE_RST;
    sens_q = SENS_MIN; inv_q = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default settings: full deflection gives 12 counts
    add_row(16'h7FFF, 16'h0000, 1, 1, 1, 17'sd11, 17'sd0);
    add_row(16'h8000, 16'h8000, 1, 1, 1, -17'sd12, 17'sd12);
    add_row(16'h0000, 16'h8000, 1, 1, 1, 17'sd0, 17'sd12);
    add_row(16'h0000, 16'h0000, 1, 1, 0, 0, 0);
    add_row(16'h8000, 16'h8000, 0, 1, 0, 0, 0);
    add_row(16'd1638, -16'sd1638, 1, 1, 0, 0, 0);
    add_row(16'd1637, 16'd1639, 1, 1, 0, 0, 0);
    add_row(16'd20000, -16'sd20000, 1, 0, 0, 0, 0);
    add_row(16'd30000, 16'd9000, 1, 0, 0, 0, 0);
    add_row(-16'sd32767, 16'h7FFF, 1, 0, 0, 0, 0);
    add_row(16'h5555, 16'hAAAA, 1, 0, 0, 0, 0);
    foreach (rows[i]) begin
      has = predict_deltas(rows[i].sx, rows[i].sy, rows[i].en, res);
      // the first row is 32767 of 32768 and is exempt: recheck the other typed rows against the predictor
      if (rows[i].fixed && i != 0 &&
          (has !== rows[i].has || (has && (res.dx !== rows[i].dx || res.dy !== rows[i].dy)))) begin
        $error("directed row %0d expected %0d/%0d got %0d/%0d", i,
               rows[i].dx, rows[i].dy, res.dx, res.dy);
        errors++;
      end
      send_sample(rows[i].sx, rows[i].sy, rows[i].en);
    end
    go_idle();

    // extremes of the registers, below-minimum writes saturate
    set_regs(32'h0, 32'h0, 32'hFFFF, 32'hFFFF, 1'b1);
    foreach (rows[i]) send_sample(rows[i].sx, rows[i].sy, rows[i].en);
    go_idle();
    set_regs(32'h7FFF, 32'hFFF, 32'h100, 32'h100, 1'b0);
    send_sample(16'h8000, 16'h7FFF, 1);
    send_sample(16'h7FFE, 16'h8001, 1);
    go_idle();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      set_regs($urandom_range(8000), $urandom, $urandom_range(65535) | (ph[0] << 15),
               $urandom_range(4000), $urandom_range(1));
      for (int k = 0; k < 200; k++)
        send_sample(rand_stick(), rand_stick(), $urandom_range(9) != 0);
      go_idle();
    end
    send_idle_pct = 0; recv_stall_pct = 0;

    $display("covered %0d sample beats, %0d delta beats, across 11 register settings",
             beats_in, beats_out);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
